// File: src/bftr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bftr_pkg - shared types and constants of the bitmap font text rasterizer
// Holds default parameter values, field widths, codes and the structs that
// travel between the front end, the draw queue and the row engine.
// ----------------------------------------------------------------------------
package bftr_pkg;

    localparam int SCREEN_WIDTH_DEF     = 480;
    localparam int SCREEN_HEIGHT_DEF    = 272;
    localparam int MAX_GLYPH_WIDTH_DEF  = 32;
    localparam int MAX_GLYPH_HEIGHT_DEF = 32;
    localparam int CODE_BITS_DEF        = 16;

    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int COORD_W     = 16;
    localparam int COLOR_W     = 32;
    localparam int CODE_W      = 16;
    localparam int MASK_W      = 33;
    localparam int POS_W       = 9;
    localparam int ROW_Y_W     = 7;
    localparam int ACC_W       = 40;
    localparam int STORE_IDX_W = 24;
    localparam int ADV_DEPTH   = 128;
    localparam int ADV_IDX_W   = 7;

    localparam int IN_TDATA_W  = 120;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 120;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_X        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_Y        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHADE_COLOR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_SPACE   = 3'd5;

    localparam logic [5:0]  GLYPH_WIDTH_RST  = 6'd16;
    localparam logic [5:0]  GLYPH_HEIGHT_RST = 6'd16;
    localparam logic [31:0] SHADE_COLOR_RST  = 32'hb000_0000;

    // Text bytes with a meaning of their own
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        KIND_TEXT  = 2'd0,
        KIND_STORE = 2'd1,
        KIND_ADV   = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic {
        F_IDLE,
        F_EXEC
    } t_fstate;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SETUP,
        B_FETCH,
        B_EMIT
    } t_bstate;

    typedef struct packed {
        logic [5:0] glyph_w;
        logic [5:0] glyph_h;
        logic [4:0] gap_x;
        logic [4:0] gap_y;
        logic       shadow_on;
        logic       draw_space;
    } t_cfg;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [COLOR_W-1:0] ink;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
    } t_draw;

endpackage

// File: src/bitmap_font_text_rasterizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_font_text_rasterizer_top - bitmap font text rasterizer
// Turns text bytes into glyph rows as foreground and shadow masks.
// ----------------------------------------------------------------------------
// Glyph rows are paced by the single byte-wide read port of the glyph store,
//   read at nb = store bytes per glyph row (0 to 5); with shadow on, one
//   extra shadow-only last row follows and reads no store bytes.
// The decoder takes one word at a time and accepts the next only once the
//   last is done; a drawn glyph waits while the draw queue is full, and a
//   store write waits until the row engine is idle and the queue is empty.
// Reset (synchronous, i_rst_n low) clears cursor, lead byte, queue and
//   output valid, and loads register defaults; the stores are not cleared.
module bitmap_font_text_rasterizer_top #(
    parameter int SCREEN_WIDTH     = bftr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT    = bftr_pkg::SCREEN_HEIGHT_DEF,
    parameter int CODE_BITS        = bftr_pkg::CODE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input words
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata, low bit up: text_byte[7:0], start_x[23:8], start_y[39:24],
    //   ink_color[71:40], store_index[95:72], store_byte[103:96],
    //   advance_index[110:104], advance_value[118:111], zero pad[119]
    input  logic [bftr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // tuser, low bit up: kind[1:0], string_start[2]
    input  logic [bftr_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    // Glyph row words; tlast marks the last row of a glyph
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata, low bit up: row_x[8:0], row_y[17:9], fg_mask[50:18],
    //   shadow_mask[83:51], out_color[115:84], zero pad[119:116]
    output logic [bftr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                              m_axis_tlast,
    // Configuration writes
    input  logic                              i_cfg_we,
    input  logic [bftr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bftr_pkg::CFG_W-1:0]        i_cfg_wdata
);

    // Cell limits are fixed by the mask and row counter widths of the package
    localparam int MAX_GLYPH_WIDTH  = bftr_pkg::MAX_GLYPH_WIDTH_DEF;
    localparam int MAX_GLYPH_HEIGHT = bftr_pkg::MAX_GLYPH_HEIGHT_DEF;

    // Glyph store: one row of MAX_GLYPH_HEIGHT holds every code's bits
    localparam int ROW_BYTES   = ((MAX_GLYPH_WIDTH << CODE_BITS) / 8) + 1;
    localparam int STORE_DEPTH = MAX_GLYPH_HEIGHT * ROW_BYTES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    logic [5:0]  r_glyph_w, r_glyph_h;
    logic [4:0]  r_gap_x, r_gap_y;
    logic [31:0] r_shade;
    logic        r_draw_space;
    logic [5:0]  cfg_v6;

    bftr_pkg::t_cfg  cfg;
    bftr_pkg::t_draw q_in, q_out;
    logic            q_push, q_pop, q_full, q_empty;
    logic            back_idle;
    logic            st_we, mem_re;
    logic [ADDR_W-1:0] st_addr, mem_addr;
    logic [7:0]      st_data, mem_q;

    assign cfg_v6 = i_cfg_wdata[5:0];

    // Configuration registers; cell sizes saturate at the maximum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_w    <= (bftr_pkg::GLYPH_WIDTH_RST > 6'(MAX_GLYPH_WIDTH)) ?
                            6'(MAX_GLYPH_WIDTH) : bftr_pkg::GLYPH_WIDTH_RST;
            r_glyph_h    <= (bftr_pkg::GLYPH_HEIGHT_RST > 6'(MAX_GLYPH_HEIGHT)) ?
                            6'(MAX_GLYPH_HEIGHT) : bftr_pkg::GLYPH_HEIGHT_RST;
            r_gap_x      <= '0;
            r_gap_y      <= '0;
            r_shade      <= bftr_pkg::SHADE_COLOR_RST;
            r_draw_space <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bftr_pkg::CFG_GLYPH_WIDTH: begin
                    r_glyph_w <= (cfg_v6 > 6'(MAX_GLYPH_WIDTH)) ? 6'(MAX_GLYPH_WIDTH) : cfg_v6;
                end
                bftr_pkg::CFG_GLYPH_HEIGHT: begin
                    r_glyph_h <= (cfg_v6 > 6'(MAX_GLYPH_HEIGHT)) ? 6'(MAX_GLYPH_HEIGHT) : cfg_v6;
                end
                bftr_pkg::CFG_GAP_X:       r_gap_x      <= i_cfg_wdata[4:0];
                bftr_pkg::CFG_GAP_Y:       r_gap_y      <= i_cfg_wdata[4:0];
                bftr_pkg::CFG_SHADE_COLOR: r_shade      <= i_cfg_wdata;
                bftr_pkg::CFG_DRAW_SPACE:  r_draw_space <= i_cfg_wdata[0];
                default:                   r_draw_space <= r_draw_space;
            endcase
        end
    end

    // Shadow mode is on whenever the shadow colour is nonzero
    always_comb begin
        cfg.glyph_w    = r_glyph_w;
        cfg.glyph_h    = r_glyph_h;
        cfg.gap_x      = r_gap_x;
        cfg.gap_y      = r_gap_y;
        cfg.shadow_on  = (r_shade != '0);
        cfg.draw_space = r_draw_space;
    end

    bftr_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .STORE_DEPTH   (STORE_DEPTH),
        .ADDR_W        (ADDR_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .i_cfg       (cfg),
        .i_back_idle (back_idle),
        .i_q_full    (q_full),
        .i_q_empty   (q_empty),
        .o_q_push    (q_push),
        .o_q_data    (q_in),
        .o_st_we     (st_we),
        .o_st_addr   (st_addr),
        .o_st_data   (st_data)
    );

    bftr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    bftr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_addr),
        .i_wdata (st_data),
        .i_re    (mem_re),
        .i_raddr (mem_addr),
        .o_rdata (mem_q)
    );

    bftr_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .CODE_BITS     (CODE_BITS),
        .ADDR_W        (ADDR_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_q_empty     (q_empty),
        .i_q_data      (q_out),
        .o_q_pop       (q_pop),
        .o_idle        (back_idle),
        .o_mem_re      (mem_re),
        .o_mem_addr    (mem_addr),
        .i_mem_q       (mem_q),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// File: src/bftr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bftr_ram - generic single write, single read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bftr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

// File: src/bftr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bftr_front - input word decoder and cursor keeper
// Takes one word at a time, applies store and table writes, tracks the
// cursor and the pending lead byte, and queues glyphs to be drawn.
// ----------------------------------------------------------------------------
module bftr_front #(
    parameter int SCREEN_WIDTH  = bftr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = bftr_pkg::SCREEN_HEIGHT_DEF,
    parameter int STORE_DEPTH   = 8388640,
    parameter int ADDR_W        = 23
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_tvalid,
    output logic                              o_tready,
    input  logic [bftr_pkg::IN_TDATA_W-1:0]   i_tdata,
    input  logic [bftr_pkg::IN_TUSER_W-1:0]   i_tuser,
    input  bftr_pkg::t_cfg                    i_cfg,
    input  logic                              i_back_idle,
    input  logic                              i_q_full,
    input  logic                              i_q_empty,
    output logic                              o_q_push,
    output bftr_pkg::t_draw                   o_q_data,
    output logic                              o_st_we,
    output logic [ADDR_W-1:0]                 o_st_addr,
    output logic [7:0]                        o_st_data
);

    bftr_pkg::t_fstate r_state, n_state;

    logic [1:0]                  r_kind;
    logic [7:0]                  r_byte;
    logic                        r_ss;
    logic [15:0]                 r_sx, r_sy;
    logic [31:0]                 r_ink;
    logic [23:0]                 r_sidx;
    logic [7:0]                  r_sbyte;
    logic [6:0]                  r_aidx;
    logic [7:0]                  r_aval;

    logic [15:0] r_cx, n_cx, r_cy, n_cy, r_ls, n_ls;
    logic        r_lp, n_lp;
    logic [7:0]  r_lb, n_lb;

    logic        accept;
    logic [7:0]  adv_q;
    logic        adv_we;
    logic [15:0] cx0, cy0, ls0;
    logic        lp0;
    logic        draw;
    logic [15:0] code;
    logic [16:0] px, py;
    logic        on_screen;
    logic        go;

    assign accept   = i_tvalid && o_tready;
    assign o_tready = (r_state == bftr_pkg::F_IDLE);

    bftr_ram #(
        .WIDTH (8),
        .DEPTH (bftr_pkg::ADV_DEPTH)
    ) u_adv_ram (
        .i_clk   (i_clk),
        .i_we    (adv_we),
        .i_waddr (r_aidx),
        .i_wdata (r_aval),
        .i_re    (accept),
        .i_raddr (i_tdata[6:0]),
        .o_rdata (adv_q)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= i_tuser[1:0];
            r_ss    <= i_tuser[2];
            r_byte  <= i_tdata[7:0];
            r_sx    <= i_tdata[23:8];
            r_sy    <= i_tdata[39:24];
            r_ink   <= i_tdata[71:40];
            r_sidx  <= i_tdata[95:72];
            r_sbyte <= i_tdata[103:96];
            r_aidx  <= i_tdata[110:104];
            r_aval  <= i_tdata[118:111];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bftr_pkg::F_IDLE;
            r_cx    <= '0;
            r_cy    <= '0;
            r_ls    <= '0;
            r_lp    <= 1'b0;
            r_lb    <= '0;
        end else begin
            r_state <= n_state;
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_ls    <= n_ls;
            r_lp    <= n_lp;
            r_lb    <= n_lb;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cx      = r_cx;
        n_cy      = r_cy;
        n_ls      = r_ls;
        n_lp      = r_lp;
        n_lb      = r_lb;
        adv_we    = 1'b0;
        o_st_we   = 1'b0;
        o_q_push  = 1'b0;
        go        = 1'b1;
        draw      = 1'b0;
        code      = {8'd0, r_byte};

        // A new string resets the cursor and drops a pending lead byte
        cx0 = r_ss ? r_sx : r_cx;
        cy0 = r_ss ? r_sy : r_cy;
        ls0 = r_ss ? r_sx : r_ls;
        lp0 = r_ss ? 1'b0 : r_lp;

        px = {cx0[15], cx0} + {16'd0, i_cfg.shadow_on};
        py = {cy0[15], cy0} + {16'd0, i_cfg.shadow_on};
        on_screen = !px[16] && !py[16] &&
                    (px < 17'(SCREEN_WIDTH)) && (py < 17'(SCREEN_HEIGHT));

        o_q_data.code = code;
        o_q_data.ink  = r_ink;
        o_q_data.px   = px[15:0];
        o_q_data.py   = py[15:0];

        unique case (r_state)
            bftr_pkg::F_IDLE: begin
                if (accept) begin
                    n_state = bftr_pkg::F_EXEC;
                end
            end
            bftr_pkg::F_EXEC: begin
                case (bftr_pkg::t_kind'(r_kind))
                    bftr_pkg::KIND_TEXT: begin
                        n_cx = cx0;
                        n_cy = cy0;
                        n_ls = ls0;
                        n_lp = lp0;
                        if (lp0) begin
                            draw = 1'b1;
                            code = {r_byte, r_lb};
                            n_cx = cx0 + 16'(i_cfg.glyph_w);
                            n_lp = 1'b0;
                        end else if (r_byte == bftr_pkg::CH_NUL) begin
                            n_cx = cx0;
                        end else if (r_byte == bftr_pkg::CH_NL) begin
                            n_cx = ls0;
                            n_cy = cy0 + 16'(i_cfg.glyph_h) + 16'(i_cfg.gap_y);
                        end else if (r_byte == bftr_pkg::CH_TAB) begin
                            n_cx = cx0 + {9'd0, i_cfg.glyph_w, 1'b0};
                        end else if (r_byte == bftr_pkg::CH_SPACE && !i_cfg.draw_space) begin
                            n_cx = cx0 + 16'(adv_q) + 16'(i_cfg.gap_x);
                        end else if (!r_byte[7]) begin
                            draw = 1'b1;
                            n_cx = cx0 + 16'(adv_q) + 16'(i_cfg.gap_x);
                        end else begin
                            n_lp = 1'b1;
                            n_lb = r_byte;
                        end
                        o_q_data.code = code;
                        if (draw && on_screen) begin
                            // Hold everything until the queue has room
                            if (i_q_full) begin
                                go = 1'b0;
                            end else begin
                                o_q_push = 1'b1;
                            end
                        end
                    end
                    bftr_pkg::KIND_STORE: begin
                        // Let queued glyphs finish reading the store first
                        if (i_back_idle && i_q_empty) begin
                            o_st_we = (r_sidx < 24'(STORE_DEPTH));
                        end else begin
                            go = 1'b0;
                        end
                    end
                    bftr_pkg::KIND_ADV: begin
                        adv_we = 1'b1;
                    end
                    default: begin
                        go = 1'b1;
                    end
                endcase
                if (go) begin
                    n_state = bftr_pkg::F_IDLE;
                end else begin
                    n_cx = r_cx;
                    n_cy = r_cy;
                    n_ls = r_ls;
                    n_lp = r_lp;
                    n_lb = r_lb;
                end
            end
            default: begin
                n_state = bftr_pkg::F_IDLE;
            end
        endcase
    end

    assign o_st_addr = r_sidx[ADDR_W-1:0];
    assign o_st_data = r_sbyte;

endmodule

// File: src/bftr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bftr_queue - two-entry draw queue
// Decouples the front end from the row engine.
// ----------------------------------------------------------------------------
module bftr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bftr_pkg::t_draw i_data,
    input  logic            i_pop,
    output bftr_pkg::t_draw o_data,
    output logic            o_full,
    output logic            o_empty
);

    bftr_pkg::t_draw r_mem [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// File: src/bftr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bftr_back - glyph row engine
// Fetches each glyph row from the store a byte at a time, forms the
// foreground and shadow masks, clips them and drives the output register.
// ----------------------------------------------------------------------------
module bftr_back #(
    parameter int SCREEN_WIDTH  = bftr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = bftr_pkg::SCREEN_HEIGHT_DEF,
    parameter int CODE_BITS     = bftr_pkg::CODE_BITS_DEF,
    parameter int ADDR_W        = 23
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bftr_pkg::t_cfg                    i_cfg,
    input  logic                              i_q_empty,
    input  bftr_pkg::t_draw                   i_q_data,
    output logic                              o_q_pop,
    output logic                              o_idle,
    output logic                              o_mem_re,
    output logic [ADDR_W-1:0]                 o_mem_addr,
    input  logic [7:0]                        i_mem_q,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [bftr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                              m_axis_tlast
);

    localparam int BITN_W = CODE_BITS + 6;
    localparam int MW     = bftr_pkg::MASK_W;

    bftr_pkg::t_bstate r_state, n_state;
    bftr_pkg::t_draw   r_desc, n_desc;

    logic [BITN_W-1:0]              r_bitn, n_bitn;
    logic [bftr_pkg::ROW_Y_W-1:0]   r_y, n_y;
    logic [ADDR_W-1:0]              r_rowbase, n_rowbase;
    logic [MW-1:0]                  r_prev, n_prev;
    logic [2:0]                     r_iss, n_iss;
    logic                           r_pend, n_pend;
    logic [bftr_pkg::ACC_W-1:0]     r_acc, n_acc;

    logic                           r_ov, n_ov;
    logic [8:0]                     r_ox, n_ox, r_oy, n_oy;
    logic [MW-1:0]                  r_ofg, n_ofg, r_osh, n_osh;
    logic [31:0]                    r_ocol, n_ocol;
    logic                           r_olast, n_olast;

    logic [bftr_pkg::ROW_Y_W-1:0]   ye;
    logic [2:0]                     off;
    logic [6:0]                     nb_sum;
    logic [2:0]                     nbytes, nb;
    logic                           fetch_row;
    logic [bftr_pkg::ACC_W-1:0]     aligned;
    logic [MW-1:0]                  grow, fg, sh, clip;
    logic [16:0]                    colmax;
    logic [15:0]                    rowy;
    logic                           last;
    logic [ADDR_W-1:0]              rowb;
    logic                           out_free;

    always_comb begin
        ye        = bftr_pkg::ROW_Y_W'(i_cfg.glyph_h) + bftr_pkg::ROW_Y_W'(i_cfg.shadow_on);
        off       = r_bitn[2:0];
        nb_sum    = 7'(off) + 7'(i_cfg.glyph_w) + 7'd7;
        nbytes    = nb_sum[5:3];
        fetch_row = (r_y < bftr_pkg::ROW_Y_W'(i_cfg.glyph_h));
        nb        = fetch_row ? nbytes : 3'd0;
        aligned   = r_acc << {3'd5 - nb, 3'b000};
        colmax    = 17'(SCREEN_WIDTH) - {1'b0, r_desc.px};
        for (int x = 0; x < MW; x++) begin
            if (x < int'(i_cfg.glyph_w) && (int'(off) + x) < bftr_pkg::ACC_W) begin
                grow[x] = aligned[bftr_pkg::ACC_W - 1 - (int'(off) + x)];
            end else begin
                grow[x] = 1'b0;
            end
            clip[x] = (17'(x) < colmax);
        end
        fg = fetch_row ? grow : '0;
        // Shadow: glyph pixel one up and left, where no ink lands
        sh = (i_cfg.shadow_on && r_y != '0) ? ({r_prev[MW-2:0], 1'b0} & ~fg) : '0;
        rowy  = r_desc.py + 16'(r_y);
        last  = ((r_y + 1'b1) == ye) || (({1'b0, rowy} + 17'd1) >= 17'(SCREEN_HEIGHT));
        rowb  = (ADDR_W'(i_cfg.glyph_w) << (CODE_BITS - 3)) + ADDR_W'(1);
        out_free = !r_ov || m_axis_tready;
    end

    always_comb begin
        n_state   = r_state;
        n_desc    = r_desc;
        n_bitn    = r_bitn;
        n_y       = r_y;
        n_rowbase = r_rowbase;
        n_prev    = r_prev;
        n_iss     = r_iss;
        n_pend    = 1'b0;
        n_acc     = r_acc;
        n_ov      = r_ov && !m_axis_tready;
        n_ox      = r_ox;
        n_oy      = r_oy;
        n_ofg     = r_ofg;
        n_osh     = r_osh;
        n_ocol    = r_ocol;
        n_olast   = r_olast;
        o_q_pop   = 1'b0;
        o_mem_re  = 1'b0;
        o_mem_addr = r_rowbase + ADDR_W'(r_bitn >> 3) + ADDR_W'(r_iss);

        unique case (r_state)
            bftr_pkg::B_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_desc  = i_q_data;
                    n_state = bftr_pkg::B_SETUP;
                end
            end
            bftr_pkg::B_SETUP: begin
                n_bitn    = BITN_W'(r_desc.code[CODE_BITS-1:0]) * BITN_W'(i_cfg.glyph_w);
                n_y       = '0;
                n_rowbase = '0;
                n_prev    = '0;
                n_iss     = '0;
                // A cell with no rows emits nothing
                n_state   = (ye == '0) ? bftr_pkg::B_IDLE : bftr_pkg::B_FETCH;
            end
            bftr_pkg::B_FETCH: begin
                // Issue one store read a cycle, shift in its data in the cycle after
                if (r_iss < nb) begin
                    o_mem_re = 1'b1;
                    n_iss    = r_iss + 3'd1;
                    n_pend   = 1'b1;
                end
                if (r_pend) begin
                    n_acc = {r_acc[bftr_pkg::ACC_W-9:0], i_mem_q};
                end
                if (r_iss >= nb && !r_pend) begin
                    n_state = bftr_pkg::B_EMIT;
                end
            end
            bftr_pkg::B_EMIT: begin
                if (out_free) begin
                    n_ov      = 1'b1;
                    n_ox      = r_desc.px[8:0];
                    n_oy      = rowy[8:0];
                    n_ofg     = fg & clip;
                    n_osh     = sh & clip;
                    n_ocol    = r_desc.ink;
                    n_olast   = last;
                    n_prev    = grow;
                    n_y       = r_y + 1'b1;
                    n_rowbase = r_rowbase + rowb;
                    n_iss     = '0;
                    n_state   = last ? bftr_pkg::B_IDLE : bftr_pkg::B_FETCH;
                end
            end
            default: begin
                n_state = bftr_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bftr_pkg::B_IDLE;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_desc    <= n_desc;
        r_bitn    <= n_bitn;
        r_y       <= n_y;
        r_rowbase <= n_rowbase;
        r_prev    <= n_prev;
        r_iss     <= n_iss;
        r_acc     <= n_acc;
        r_ox      <= n_ox;
        r_oy      <= n_oy;
        r_ofg     <= n_ofg;
        r_osh     <= n_osh;
        r_ocol    <= n_ocol;
        r_olast   <= n_olast;
    end

    assign o_idle        = (r_state == bftr_pkg::B_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {4'd0, r_ocol, r_osh, r_ofg, r_oy, r_ox};

endmodule

// File: src/bftr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bftr_checker - port checks for the rasterizer
// Watches the row output for stalls, screen bounds and mask overlap.
// ----------------------------------------------------------------------------
module bftr_checker #(
    parameter int SCREEN_WIDTH  = bftr_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = bftr_pkg::SCREEN_HEIGHT_DEF
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [bftr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("row word changed while stalled");

    a_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[8:0]) < 32'(SCREEN_WIDTH)))
        else $error("row_x off screen");

    a_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[17:9]) < 32'(SCREEN_HEIGHT)))
        else $error("row_y off screen");

    a_masks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[50:18] & m_axis_tdata[83:51]) == '0))
        else $error("foreground and shadow masks overlap");

endmodule

bind bitmap_font_text_rasterizer_top bftr_checker #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_bftr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
